[rtl/stereo_point_triangulation_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the stereo triangulation block
// Implication checks on the block's own clock, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef STEREO_POINT_TRIANGULATION_ASSERT_SVH
`define STEREO_POINT_TRIANGULATION_ASSERT_SVH

// same-cycle implication, masked while reset is high
`define SPT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, also checked across reset
`define SPT_ASSERT_NXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/spt_pkg.sv]
// ----------------------------------------------------------------------------
// spt_pkg
// Shared widths, register indexes, sideband type and saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package spt_pkg;

   localparam int unsigned PIX_W   = 16;   // Q12.4 pixel coordinate
   localparam int unsigned CAL_W   = 24;   // focal / baseline registers
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned QUO_W   = 32;   // quotient bits, one per cell
   localparam int unsigned DVZ_W   = 20;   // 16*d
   localparam int unsigned DVX_W   = 16;   // d
   localparam int unsigned DVY_W   = 40;   // d*fy
   localparam int unsigned PNT_W   = 32;
   localparam int unsigned DEP_W   = 31;

   localparam logic [CAL_W-1:0] FOCAL_RST = 24'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CALIBRATED  = 3'd0,
      CSR_FOCAL_X     = 3'd1,
      CSR_FOCAL_Y     = 3'd2,
      CSR_PRINCIPAL_X = 3'd3,
      CSR_PRINCIPAL_Y = 3'd4,
      CSR_BASELINE    = 3'd5
   } csr_index_type;

   // per-item flags that travel alongside the divider row
   typedef struct packed {
      logic ok;      // calibrated and positive disparity
      logic xneg;
      logic yneg;
      logic yzero;   // y numerator is zero
      logic zovf;    // quotient would not fit 32 bits
      logic xovf;
      logic yovf;
   } sb_type;

   // signed 32-bit result from a 32-bit magnitude, overflow flag and sign
   function automatic logic [PNT_W-1:0] sat_s32(input logic [QUO_W-1:0] mag,
                                                input logic ovf,
                                                input logic neg);
      logic [PNT_W-1:0] r;
      if (neg) begin
         r = (ovf || mag[QUO_W-1]) ? 32'h8000_0000 : (32'd0 - mag);
      end else begin
         r = (ovf || mag[QUO_W-1]) ? 32'h7FFF_FFFF : mag;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/stereo_point_triangulation.sv]
// ----------------------------------------------------------------------------
// stereo_point_triangulation
// Rectified stereo triangulation: depth and lateral position of a matched
// point pair in Q16.16, through three rows of pipelined division cells.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------
//  req_     | in        | req_valid/req_ready | left_x, left_y, right_x
//  rsp_     | out       | rsp_valid/rsp_ready | valid_res, point_x/y/z
//  csr_     | in        | csr_we              | csr_index, csr_wdata
//
//  One transfer per cycle in and out while rsp_ready holds; 4 setup stages,
//  32 division cells, output register.
//  The 32-cell divider rows set the depth; every stage advances on its own
//  when the stage after it is empty or moving, so bubbles close up.
//  Synchronous active-high reset clears all stage valid bits; the CSRs go
//  to zero except the focal lengths, which reset to 256. A stalled rsp_
//  holds its result; req_ready drops only when every stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_point_triangulation (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [spt_pkg::PIX_W-1:0]     req_left_x,
   input  wire logic [spt_pkg::PIX_W-1:0]     req_left_y,
   input  wire logic [spt_pkg::PIX_W-1:0]     req_right_x,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid_res,
   output logic signed [spt_pkg::PNT_W-1:0]   rsp_point_x,
   output logic signed [spt_pkg::PNT_W-1:0]   rsp_point_y,
   output logic      [spt_pkg::DEP_W-1:0]     rsp_point_z,
   input  wire logic                          csr_we,
   input  wire logic [spt_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [spt_pkg::CAL_W-1:0]     csr_wdata
);

`include "stereo_point_triangulation_assert.svh"

   localparam int unsigned QW  = spt_pkg::QUO_W;
   localparam int unsigned NST = QW + 5;        // setup A..D, cells, output
   localparam int unsigned OUT = NST - 1;

   // ---------------------------------------------------------------- CSRs
   logic                      calib_ff;
   logic [spt_pkg::CAL_W-1:0] focal_x_ff;
   logic [spt_pkg::CAL_W-1:0] focal_y_ff;
   logic [spt_pkg::PIX_W-1:0] princ_x_ff;
   logic [spt_pkg::PIX_W-1:0] princ_y_ff;
   logic [spt_pkg::CAL_W-1:0] base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_ff   <= 1'b0;
         focal_x_ff <= spt_pkg::FOCAL_RST;
         focal_y_ff <= spt_pkg::FOCAL_RST;
         princ_x_ff <= '0;
         princ_y_ff <= '0;
         base_ff    <= '0;
      end else if (csr_we) begin
         unique case (spt_pkg::csr_index_type'(csr_index))
            spt_pkg::CSR_CALIBRATED:  calib_ff   <= csr_wdata[0];
            spt_pkg::CSR_FOCAL_X:     focal_x_ff <= csr_wdata;
            spt_pkg::CSR_FOCAL_Y:     focal_y_ff <= csr_wdata;
            spt_pkg::CSR_PRINCIPAL_X: princ_x_ff <= csr_wdata[spt_pkg::PIX_W-1:0];
            spt_pkg::CSR_PRINCIPAL_Y: princ_y_ff <= csr_wdata[spt_pkg::PIX_W-1:0];
            spt_pkg::CSR_BASELINE:    base_ff    <= csr_wdata;
            default: ;                // drop writes beyond the register list
         endcase
      end
   end

   // --------------------------------------------------- stage flow control
   // Stage k loads when it is empty or its content moves on this cycle.
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;
   logic [NST-1:0] en;

   assign en[OUT] = !vld_ff[OUT] || rsp_ready;
   for (genvar k = 0; k < OUT; k++) begin : g_en
      assign en[k] = !vld_ff[k] || en[k+1];
   end

   assign vld_in = {vld_ff[NST-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (en[k]) vld_ff[k] <= vld_in[k];
         end
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[OUT];

   // ------------------------------------------- stage A: disparity, deltas
   logic                      a_ok_ff, a_xneg_ff, a_yneg_ff;
   logic [spt_pkg::PIX_W-1:0] a_d_ff, a_dx_ff, a_dy_ff;
   logic                      xneg_in, yneg_in;

   assign xneg_in = req_left_x < princ_x_ff;
   assign yneg_in = req_left_y < princ_y_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         a_ok_ff   <= calib_ff && (req_left_x > req_right_x);
         a_d_ff    <= req_left_x - req_right_x;
         a_xneg_ff <= xneg_in;
         a_yneg_ff <= yneg_in;
         a_dx_ff   <= xneg_in ? (princ_x_ff - req_left_x) : (req_left_x - princ_x_ff);
         a_dy_ff   <= yneg_in ? (princ_y_ff - req_left_y) : (req_left_y - princ_y_ff);
      end
   end

   // --------------------------------------------- stage B: first products
   logic                      b_ok_ff, b_xneg_ff, b_yneg_ff;
   logic [spt_pkg::PIX_W-1:0] b_d_ff, b_dy_ff;
   logic [47:0]               b_fb_ff;
   logic [39:0]               b_nx_ff;
   logic [39:0]               b_den_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         b_ok_ff   <= a_ok_ff;
         b_xneg_ff <= a_xneg_ff;
         b_yneg_ff <= a_yneg_ff;
         b_d_ff    <= a_d_ff;
         b_dy_ff   <= a_dy_ff;
         b_fb_ff   <= 48'(focal_x_ff) * 48'(base_ff);
         b_nx_ff   <= 40'(a_dx_ff) * 40'(base_ff);
         b_den_ff  <= 40'(a_d_ff) * 40'(focal_y_ff);
      end
   end

   // ------------------------------------ stage C: dy * fb as two halves
   logic                      c_ok_ff, c_xneg_ff, c_yneg_ff, c_yzero_ff;
   logic [spt_pkg::PIX_W-1:0] c_d_ff;
   logic [47:0]               c_fb_ff;
   logic [39:0]               c_nx_ff, c_den_ff, c_plo_ff, c_phi_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         c_ok_ff    <= b_ok_ff;
         c_xneg_ff  <= b_xneg_ff;
         c_yneg_ff  <= b_yneg_ff;
         c_yzero_ff <= (b_dy_ff == '0) || (b_fb_ff == '0);
         c_d_ff     <= b_d_ff;
         c_fb_ff    <= b_fb_ff;
         c_nx_ff    <= b_nx_ff;
         c_den_ff   <= b_den_ff;
         c_plo_ff   <= 40'(b_dy_ff) * 40'(b_fb_ff[23:0]);
         c_phi_ff   <= 40'(b_dy_ff) * 40'(b_fb_ff[47:24]);
      end
   end

   // ------------------------- stage D: y numerator, quotient range checks
   // A quotient fits 32 bits exactly when the numerator's upper part is
   // below the divisor; otherwise flag it for saturation.
   logic [63:0]               ny_in;
   spt_pkg::sb_type           d_sb_in, d_sb_ff;
   logic [spt_pkg::PIX_W-1:0] d_d_ff;
   logic [47:0]               d_fb_ff;
   logic [39:0]               d_nx_ff, d_den_ff;
   logic [63:0]               d_ny_ff;

   assign ny_in = {c_phi_ff, 24'd0} + 64'(c_plo_ff);

   always_comb begin
      d_sb_in.ok    = c_ok_ff;
      d_sb_in.xneg  = c_xneg_ff;
      d_sb_in.yneg  = c_yneg_ff;
      d_sb_in.yzero = c_yzero_ff;
      d_sb_in.zovf  = {4'd0, c_fb_ff[47:32]} >= {c_d_ff, 4'd0};
      d_sb_in.xovf  = {8'd0, c_nx_ff[39:32]} >= c_d_ff;
      d_sb_in.yovf  = {8'd0, ny_in[63:32]} >= c_den_ff;
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         d_sb_ff  <= d_sb_in;
         d_d_ff   <= c_d_ff;
         d_fb_ff  <= c_fb_ff;
         d_nx_ff  <= c_nx_ff;
         d_den_ff <= c_den_ff;
         d_ny_ff  <= ny_in;
      end
   end

   // ----------------------------------------------------- division rows
   logic [QW-1:0] cell_en;
   logic [QW-1:0] qz, qx, qy;

   assign cell_en = en[OUT-1:4];

   spt_divider #(.DW(spt_pkg::DVZ_W)) u_div_z (
      .clock (clock),
      .en    (cell_en),
      .rem   ({4'd0, d_fb_ff[47:32]}),
      .lo    (d_fb_ff[31:0]),
      .dvs   ({d_d_ff, 4'd0}),
      .quo   (qz)
   );

   spt_divider #(.DW(spt_pkg::DVX_W)) u_div_x (
      .clock (clock),
      .en    (cell_en),
      .rem   ({8'd0, d_nx_ff[39:32]}),
      .lo    (d_nx_ff[31:0]),
      .dvs   (d_d_ff),
      .quo   (qx)
   );

   spt_divider #(.DW(spt_pkg::DVY_W)) u_div_y (
      .clock (clock),
      .en    (cell_en),
      .rem   ({8'd0, d_ny_ff[63:32]}),
      .lo    (d_ny_ff[31:0]),
      .dvs   (d_den_ff),
      .quo   (qy)
   );

   // carry the flags along with the cells
   spt_pkg::sb_type sb_ff [0:QW-1];

   always_ff @(posedge clock) begin
      for (int j = 0; j < QW; j++) begin
         if (cell_en[j]) sb_ff[j] <= (j == 0) ? d_sb_ff : sb_ff[(j == 0) ? 0 : j - 1];
      end
   end

   // -------------------------------------- output stage: sign, saturate
   spt_pkg::sb_type          sb_last;
   logic                     res_in;
   logic [spt_pkg::PNT_W-1:0] px_in, py_in;
   logic [spt_pkg::DEP_W-1:0] pz_in;
   logic                     res_ff;
   logic [spt_pkg::PNT_W-1:0] px_ff, py_ff;
   logic [spt_pkg::DEP_W-1:0] pz_ff;

   assign sb_last = sb_ff[QW-1];

   always_comb begin
      res_in = sb_last.ok;
      px_in  = '0;
      py_in  = '0;
      pz_in  = '0;
      if (sb_last.ok) begin
         pz_in = (sb_last.zovf || qz[QW-1]) ? {spt_pkg::DEP_W{1'b1}}
                                             : qz[spt_pkg::DEP_W-1:0];
         px_in = spt_pkg::sat_s32(qx, sb_last.xovf, sb_last.xneg);
         if (!sb_last.yzero) py_in = spt_pkg::sat_s32(qy, sb_last.yovf, sb_last.yneg);
      end
   end

   always_ff @(posedge clock) begin
      if (en[OUT]) begin
         res_ff <= res_in;
         px_ff  <= px_in;
         py_ff  <= py_in;
         pz_ff  <= pz_in;
      end
   end

   assign rsp_valid_res = res_ff;
   assign rsp_point_x   = px_ff;
   assign rsp_point_y   = py_ff;
   assign rsp_point_z   = pz_ff;

   // -------------------------------------------------------- assertions
   `SPT_ASSERT_IMP(a_invalid_zero, clock, reset, rsp_valid && !rsp_valid_res,
      rsp_point_x == '0 && rsp_point_y == '0 && rsp_point_z == '0,
      "invalid result carries nonzero coordinates")
   `SPT_ASSERT_IMP(a_stall_full, clock, reset, !req_ready,
      rsp_valid && !rsp_ready && vld_ff[0],
      "input stalled while pipeline has room")
   `SPT_ASSERT_NXT(a_reset_empty, clock, reset, !rsp_valid && req_ready,
      "pipeline not empty after reset")

endmodule

`default_nettype wire

[rtl/spt_div_cell.sv]
// ----------------------------------------------------------------------------
// spt_div_cell
// One restoring-division step: shift in a numerator bit, try the subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_div_cell #(
   parameter int unsigned DW = spt_pkg::DVY_W
) (
   input  wire logic                      clock,
   input  wire logic                      en,
   input  wire logic [DW-1:0]             rem_i,
   input  wire logic [spt_pkg::QUO_W-1:0] lo_i,
   input  wire logic [spt_pkg::QUO_W-1:0] q_i,
   input  wire logic [DW-1:0]             dv_i,
   output logic      [DW-1:0]             rem_o,
   output logic      [spt_pkg::QUO_W-1:0] lo_o,
   output logic      [spt_pkg::QUO_W-1:0] q_o,
   output logic      [DW-1:0]             dv_o
);

   localparam int unsigned QW = spt_pkg::QUO_W;

   logic [DW:0]    trial;
   logic [DW:0]    diff;
   logic           ge;
   logic [DW-1:0]  rem_in;
   logic [DW-1:0]  rem_ff;
   logic [QW-1:0]  lo_ff;
   logic [QW-1:0]  q_ff;
   logic [DW-1:0]  dv_ff;

   assign trial  = {rem_i, lo_i[QW-1]};
   assign diff   = trial - {1'b0, dv_i};
   assign ge     = (trial >= {1'b0, dv_i});
   assign rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         lo_ff  <= {lo_i[QW-2:0], 1'b0};
         q_ff   <= {q_i[QW-2:0], ge};
         dv_ff  <= dv_i;
      end
   end

   assign rem_o = rem_ff;
   assign lo_o  = lo_ff;
   assign q_o   = q_ff;
   assign dv_o  = dv_ff;

endmodule

`default_nettype wire

[rtl/spt_divider.sv]
// ----------------------------------------------------------------------------
// spt_divider
// Row of division cells, one quotient bit per cell, one stage per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_divider #(
   parameter int unsigned DW = spt_pkg::DVY_W
) (
   input  wire logic                      clock,
   input  wire logic [spt_pkg::QUO_W-1:0] en,
   input  wire logic [DW-1:0]             rem,
   input  wire logic [spt_pkg::QUO_W-1:0] lo,
   input  wire logic [DW-1:0]             dvs,
   output logic      [spt_pkg::QUO_W-1:0] quo
);

   localparam int unsigned QW = spt_pkg::QUO_W;

   logic [DW-1:0] rem_c [0:QW];
   logic [QW-1:0] lo_c  [0:QW];
   logic [QW-1:0] q_c   [0:QW];
   logic [DW-1:0] dv_c  [0:QW];

   assign rem_c[0] = rem;
   assign lo_c[0]  = lo;
   assign q_c[0]   = '0;
   assign dv_c[0]  = dvs;

   for (genvar j = 0; j < QW; j++) begin : g_cell
      spt_div_cell #(.DW(DW)) u_cell (
         .clock (clock),
         .en    (en[j]),
         .rem_i (rem_c[j]),
         .lo_i  (lo_c[j]),
         .q_i   (q_c[j]),
         .dv_i  (dv_c[j]),
         .rem_o (rem_c[j+1]),
         .lo_o  (lo_c[j+1]),
         .q_o   (q_c[j+1]),
         .dv_o  (dv_c[j+1])
      );
   end

   assign quo = q_c[QW];

endmodule

`default_nettype wire
